// ===== src/bounded_deque_with_positional_remove_defines.svh =====
// Assertion helpers for the deque block.
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_DEFINES_SVH

// Same-cycle implication, silent during reset.
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, silent during reset.
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bdq_pkg.sv =====
package bdq_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 5;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] K_REMOVE     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INS_FRONT,
		CMD_INS_AT,
		CMD_REMOVE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		idx_t      sel;
		word_t     payload;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SUMM
	} state_t;

endpackage

// ===== src/bdq_cell.sv =====
module bdq_cell (
	input  logic              clk,
	input  bdq_pkg::cell_ctl_t ctl,
	input  bdq_pkg::idx_t     idx,
	input  bdq_pkg::word_t    prev_data,
	input  bdq_pkg::word_t    next_data,
	input  bdq_pkg::word_t    pick_in,
	output bdq_pkg::word_t    data_out,
	output bdq_pkg::word_t    pick_out
);
	import bdq_pkg::*;

	word_t data_q;
	logic  hit;

	assign hit      = (idx == ctl.sel);
	assign data_out = data_q;
	// merge this cell's word into the pick chain when selected
	assign pick_out = pick_in | (hit ? data_q : '0);

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INS_FRONT: data_q <= (idx == '0) ? ctl.payload : prev_data;
			CMD_INS_AT:    if (hit) data_q <= ctl.payload;
			CMD_REMOVE:    if (idx >= ctl.sel) data_q <= next_data;
			default:       data_q <= data_q;
		endcase
	end

endmodule

// ===== src/bounded_deque_with_positional_remove.sv =====
// Each item passes idle (accept), execute, then summary with output load.
// The sequencer takes no new item until the last is through: it shifts or loads the cells
//   in execute, then reads the back word through the pick chain in summary until the output is free.
// Reset (arst_n low, asynchronous): entry count, sequencer and output valid cleared;
//   cell words are not cleared and are only read once written.
`include "bounded_deque_with_positional_remove_defines.svh"

module bounded_deque_with_positional_remove (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // payload[31:0], position[36:32], zero pad[39:37]
	input  logic [2:0]   s_tuser,  // kind[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata   // status[1:0], removed_word[33:2], front_word[65:34],
	                               // back_word[97:66], entry_count[102:98], is_empty[103]
);
	import bdq_pkg::*;

	// Row of cells: cell i holds the entry at logical position i from the front.
	word_t cell_data [DEPTH];
	word_t pick      [DEPTH+1];
	cell_ctl_t ctl;

	state_t state_q, state_d;

	// Latched request
	logic [KIND_W-1:0] kind_q;
	word_t             payload_q;
	logic [POS_W-1:0]  pos_q;

	cnt_t               count_q, count_d;
	logic [STAT_W-1:0]  status_q, status_d;
	word_t              removed_q;

	// Output register
	logic               m_valid_q;
	logic [STAT_W-1:0]  m_status_q;
	word_t              m_removed_q, m_front_q, m_back_q;
	cnt_t               m_count_q;
	logic               m_empty_q;

	logic full, empty, pos_bad, out_free;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_bad  = (pos_q == '0) || (CMP_W'(pos_q) > CMP_W'(count_q));
	assign out_free = !m_valid_q || m_tready;

	assign pick[0] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			bdq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.idx       (IDX_W'(gi)),
				.prev_data ((gi == 0) ? word_t'('0) : cell_data[(gi == 0) ? 0 : gi-1]),
				.next_data ((gi == DEPTH-1) ? word_t'('0)
				                            : cell_data[(gi == DEPTH-1) ? gi : gi+1]),
				.pick_in   (pick[gi]),
				.data_out  (cell_data[gi]),
				.pick_out  (pick[gi+1])
			);
		end
	endgenerate

	// Sequencer: decode the request in execute, read back word in summary.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		status_d    = status_q;
		ctl.cmd     = CMD_NONE;
		ctl.sel     = '0;
		ctl.payload = payload_q;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				status_d = ST_OK;
				case (kind_q)
					K_PUSH_FRONT: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							ctl.cmd = CMD_INS_FRONT;
							count_d = count_q + 1'b1;
						end
					end
					K_PUSH_BACK: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							ctl.cmd = CMD_INS_AT;
							ctl.sel = IDX_W'(count_q);
							count_d = count_q + 1'b1;
						end
					end
					K_POP_FRONT: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							ctl.cmd = CMD_REMOVE;
							count_d = count_q - 1'b1;
						end
					end
					K_POP_BACK: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							// drop the last entry; cells past it take stale words
							ctl.cmd = CMD_REMOVE;
							ctl.sel = IDX_W'(count_q - 1'b1);
							count_d = count_q - 1'b1;
						end
					end
					K_REMOVE: begin
						if (pos_bad) begin
							status_d = ST_BADPOS;
						end else begin
							// close the gap: cells from the position onward advance
							ctl.cmd = CMD_REMOVE;
							ctl.sel = IDX_W'(pos_q - 1'b1);
							count_d = count_q - 1'b1;
						end
					end
					default: ;
				endcase
				state_d = S_SUMM;
			end
			S_SUMM: begin
				// point the pick chain at the new back entry
				ctl.sel = IDX_W'(count_q - 1'b1);
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_SUMM && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			kind_q    <= s_tuser;
			payload_q <= s_tdata[31:0];
			pos_q     <= s_tdata[36:32];
		end
		if (state_q == S_EXEC) begin
			status_q  <= status_d;
			// pick chain still sees the words before the shift
			removed_q <= (ctl.cmd == CMD_REMOVE) ? pick[DEPTH] : '0;
		end
		if (state_q == S_SUMM && out_free) begin
			m_status_q  <= status_q;
			m_removed_q <= removed_q;
			m_front_q   <= empty ? '0 : cell_data[0];
			m_back_q    <= empty ? '0 : pick[DEPTH];
			m_count_q   <= count_q;
			m_empty_q   <= empty;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_empty_q, m_count_q, m_back_q, m_front_q, m_removed_q, m_status_q};

	`BDQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count beyond depth")
	`BDQ_ASSERT_IMP(a_full_status, state_q == S_EXEC && status_d == ST_FULL, full,
		"full status with room left")
	`BDQ_ASSERT_IMP(a_empty_flag, m_valid_q, m_empty_q == (m_count_q == '0),
		"empty flag disagrees with count")
	`BDQ_ASSERT_NXT(a_summ_stall, state_q == S_SUMM && m_valid_q && !m_tready,
		state_q == S_SUMM, "result overwritten while output stalled")

endmodule

// ===== bench/tb.sv =====
module tb;
	import bdq_pkg::*;

	// Kind codes above the remove operation are spare and act as no-ops.
	localparam logic [KIND_W-1:0] K_SPARE_FIRST = K_REMOVE + 1'b1;
	localparam logic [KIND_W-1:0] K_SPARE_LAST  = '1;
	localparam word_t WORD_ONES = '1;

	localparam int DATA_PAD     = 40 - POS_W - WORD_W;
	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_PERIOD  = 2500;   // receiver cycles between long hold-offs
	localparam int LONG_HOLD    = 200;    // length of one long hold-off
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int REPORT_MAX   = 10;

	// One result, laid out exactly as m_tdata: status in the lowest bits.
	typedef struct packed {
		logic        is_empty;
		cnt_t        entry_count;
		word_t       back_word;
		word_t       front_word;
		word_t       removed_word;
		logic [1:0]  status;
	} deque_result_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		word_t             payload;
		logic [POS_W-1:0]  pos;
		bit                by_hand;
		deque_result_t     want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;    // payload[31:0], position[36:32], zero pad[39:37]
	logic [2:0] s_tuser = '0;     // kind[2:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;        // status, removed_word, front_word, back_word,
	                              // entry_count, is_empty

	// Shadow copy of the deque: circular store addressed from the front slot.
	word_t store [DEPTH];
	cnt_t  fill = '0;
	idx_t  head = '0;

	deque_result_t pending_results[$];
	int mismatches = 0;
	int burst_left = 1;

	bounded_deque_with_positional_remove dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Physical slot of the entry k places behind the front.
	function automatic idx_t phys_slot(int k);
		return idx_t'((int'(head) + k) % DEPTH);
	endfunction

	function automatic deque_result_t summary_of(logic [1:0] st, word_t removed, word_t front,
			word_t back, int count);
		deque_result_t r;
		r.status       = st;
		r.removed_word = removed;
		r.front_word   = front;
		r.back_word    = back;
		r.entry_count  = cnt_t'(count);
		r.is_empty     = (count == 0);
		return r;
	endfunction

	// Apply one request to the shadow deque and return the result it must produce.
	function automatic deque_result_t apply_request(logic [KIND_W-1:0] kind, word_t w,
			logic [POS_W-1:0] pos);
		deque_result_t r;
		r = '0;
		r.status = ST_OK;
		case (kind)
			K_PUSH_FRONT: begin
				if (fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					head = phys_slot(DEPTH - 1);
					store[head] = w;
					fill++;
				end
			end
			K_PUSH_BACK: begin
				if (fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					store[phys_slot(fill)] = w;
					fill++;
				end
			end
			K_POP_FRONT: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_word = store[head];
					head = phys_slot(1);
					fill--;
				end
			end
			K_POP_BACK: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_word = store[phys_slot(fill - 1)];
					fill--;
				end
			end
			K_REMOVE: begin
				if (pos == 0 || pos > fill) begin
					r.status = ST_BADPOS;
				end else begin
					r.removed_word = store[phys_slot(pos - 1)];
					// close the gap, keeping order
					for (int k = pos - 1; k + 1 < fill; k++)
						store[phys_slot(k)] = store[phys_slot(k + 1)];
					fill--;
				end
			end
			default: ;
		endcase
		if (fill != 0) begin
			r.front_word = store[head];
			r.back_word  = store[phys_slot(fill - 1)];
		end
		r.entry_count = fill;
		r.is_empty    = (fill == 0);
		return r;
	endfunction

	// Offer one item, hold it until accepted, then record the result it must give.
	// Between bursts drop tvalid for a random gap; inside a burst keep it high.
	task automatic offer_request(logic [KIND_W-1:0] kind, word_t w, logic [POS_W-1:0] pos,
			bit by_hand, deque_result_t want);
		deque_result_t model;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{DATA_PAD{1'b0}}, pos, w};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model = apply_request(kind, w, pos);
		pending_results.push_back(by_hand ? want : model);
		burst_left--;
		if (burst_left == 0) begin
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic flag_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch in %s: expected %h, got %h", what, want_v, got_v);
	endtask

	// Compare every accepted result with the oldest pending one, field by field.
	always @(posedge clk) begin : result_check
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", '0, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					flag_mismatch("status", want.status, got.status);
				if (got.removed_word !== want.removed_word)
					flag_mismatch("removed_word", want.removed_word, got.removed_word);
				if (got.front_word !== want.front_word)
					flag_mismatch("front_word", want.front_word, got.front_word);
				if (got.back_word !== want.back_word)
					flag_mismatch("back_word", want.back_word, got.back_word);
				if (got.entry_count !== want.entry_count)
					flag_mismatch("entry_count", want.entry_count, got.entry_count);
				if (got.is_empty !== want.is_empty)
					flag_mismatch("is_empty", want.is_empty, got.is_empty);
			end
		end
	end

	// Result sink: stall in changing moods, and every so often hold off for a
	// long stretch so that the block backs up and stalls its input.
	initial begin : result_sink
		int hold;
		int mood_left;
		int stall_pct;
		int since_hold;
		hold = 0;
		mood_left = 0;
		stall_pct = 0;
		since_hold = 0;
		forever begin
			@(posedge clk);
			since_hold++;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (since_hold >= HOLD_PERIOD) begin
				since_hold = 0;
				hold = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				if (mood_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 80;
					endcase
					mood_left = $urandom_range(20, 200);
				end
				mood_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Give up on a hung run.
	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		dir_row_t dir_rows[$];
		logic [KIND_W-1:0] kind;
		word_t w;
		logic [POS_W-1:0] pos;
		int counted;
		int push_pct;
		int trend_left;

		// Directed table. Rows with an expectation typed in are the empty-queue errors,
		// a spare kind and the first two pushes; the rest go through the shadow deque.
		dir_rows.push_back('{K_POP_FRONT, WORD_ONES, 5'd0, 1'b1,
			summary_of(ST_EMPTY, '0, '0, '0, 0)});
		dir_rows.push_back('{K_POP_BACK, WORD_ONES, 5'd31, 1'b1,
			summary_of(ST_EMPTY, '0, '0, '0, 0)});
		dir_rows.push_back('{K_REMOVE, '0, 5'd0, 1'b1,
			summary_of(ST_BADPOS, '0, '0, '0, 0)});
		dir_rows.push_back('{K_REMOVE, '0, 5'd1, 1'b1,
			summary_of(ST_BADPOS, '0, '0, '0, 0)});
		dir_rows.push_back('{K_SPARE_LAST, WORD_ONES, 5'd1, 1'b1,
			summary_of(ST_OK, '0, '0, '0, 0)});
		dir_rows.push_back('{K_PUSH_BACK, WORD_ONES, 5'd0, 1'b1,
			summary_of(ST_OK, '0, WORD_ONES, WORD_ONES, 1)});
		dir_rows.push_back('{K_PUSH_FRONT, '0, 5'd0, 1'b1,
			summary_of(ST_OK, '0, '0, WORD_ONES, 2)});
		// fill to the brim from both ends
		for (int i = 0; i < DEPTH - 2; i++)
			dir_rows.push_back('{i[0] ? K_PUSH_FRONT : K_PUSH_BACK,
				word_t'(32'hA5C3_0000 + i * 32'h0101_1111), 5'd0, 1'b0, '0});
		dir_rows.push_back('{K_PUSH_FRONT, 32'h1234_5678, 5'd0, 1'b0, '0});
		dir_rows.push_back('{K_PUSH_BACK, 32'h8765_4321, 5'd0, 1'b0, '0});
		dir_rows.push_back('{K_REMOVE, '0, 5'd17, 1'b0, '0});
		dir_rows.push_back('{K_REMOVE, '0, 5'd16, 1'b0, '0});
		dir_rows.push_back('{K_REMOVE, '0, 5'd1, 1'b0, '0});
		dir_rows.push_back('{K_REMOVE, '0, 5'd7, 1'b0, '0});
		dir_rows.push_back('{K_POP_FRONT, '0, 5'd0, 1'b0, '0});
		dir_rows.push_back('{K_POP_BACK, '0, 5'd0, 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer_request(dir_rows[i].kind, dir_rows[i].payload, dir_rows[i].pos,
				dir_rows[i].by_hand, dir_rows[i].want);

		// Random part: alternate filling and draining trends so that the deque
		// keeps reaching both full and empty, with valid positions mostly.
		counted = 0;
		push_pct = 50;
		trend_left = 0;
		while (counted < RANDOM_ITEMS) begin
			if (trend_left == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
				trend_left = $urandom_range(30, 120);
			end
			trend_left--;

			if ($urandom_range(0, 99) < 3) begin
				kind = KIND_W'($urandom_range(int'(K_SPARE_LAST), int'(K_SPARE_FIRST)));
			end else if ($urandom_range(0, 99) < push_pct) begin
				kind = $urandom_range(0, 1) ? K_PUSH_FRONT : K_PUSH_BACK;
			end else begin
				case ($urandom_range(0, 2))
					0: kind = K_POP_FRONT;
					1: kind = K_POP_BACK;
					default: kind = K_REMOVE;
				endcase
			end

			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = WORD_ONES;
				default: w = $urandom;
			endcase

			if (fill != 0 && $urandom_range(0, 99) < 85)
				pos = POS_W'($urandom_range(1, int'(fill)));
			else
				pos = POS_W'($urandom_range(0, 31));

			offer_request(kind, w, pos, 1'b0, '0);
			if (kind <= K_REMOVE)
				counted++;
		end
		s_tvalid <= 1'b0;

		// Wait for every pending result, then give the block time to misbehave.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
